// ===== rtl/icf_pkg.sv =====
// Shared types and constants for the inline comment filter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package icf_pkg;
   localparam logic [2:0] CSR_ENCODE_MODE = 3'd0;
   localparam logic [2:0] CSR_COMMENT_SEQ = 3'd1;
   localparam logic [2:0] CSR_COMMENT_LEN = 3'd2;
   localparam logic [2:0] CSR_OPTION_FLAGS = 3'd3;
   localparam logic [2:0] CSR_INFO_STARTER = 3'd4;
   localparam logic [2:0] CSR_INFO_STARTER_LEN = 3'd5;

   localparam int OPT_REMOVE_EMPTY = 0;
   localparam int OPT_SQUEEZE = 1;
   localparam int OPT_FOLLOW_WS = 2;
   localparam int OPT_LINE_INFO = 3;

   // most result beats one input byte may cause; later ones are dropped
   localparam int RESULT_LIMIT = 33;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_LF = 8'h0a;
   localparam logic [7:0] CHAR_ZERO = 8'h30;

   typedef enum logic [2:0] {
      ST_INITIAL, ST_NEWLINE, ST_COPY, ST_COMMENT, ST_PARTIAL, ST_COMMENT_WS, ST_WS
   } line_state_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c >= 8'd9 && c <= 8'd13);
   endfunction
endpackage
`default_nettype wire

// ===== rtl/inline_comment_filter_core.sv =====
// Inline comment filter top level: line state machine, replay sequencer,
// whitespace store memory. Depends on icf_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Filters a byte stream one beat at a time. Decode mode removes lines that open
// with the comment sequence, replaying partial matches and held whitespace;
// encode mode prefixes every line. A plain byte is first accepted and then
// evaluated, and the input is not ready again until the byte is done. Replays
// add steps for each comment sequence, starter, space, digit or newline beat,
// for each skipped leading zero of the line number, a registered memory read
// and then the beat for each held whitespace entry, and a return to evaluation
// at the end of each comment sequence or whitespace replay. Result beats leave
// through an output register; every cycle in which that register is full and
// not taken holds the sequencer.
module inline_comment_filter_core #(
   parameter int MAX_COMMENT_LEN = 8,
   parameter int WS_DEPTH = 32,
   parameter int MAX_STARTER_LEN = 8,
   parameter int LINE_DIGITS = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_of_run,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   localparam int WSC_W = $clog2(WS_DEPTH + 1);
   localparam int WSA_W = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;
   localparam int DIG_W = (LINE_DIGITS > 1) ? $clog2(LINE_DIGITS) : 1;
   localparam int CNT_W = 4 * LINE_DIGITS;
   // held whitespace replayed before the byte itself, within the result limit
   localparam int WS_REPLAY = (WS_DEPTH < icf_pkg::RESULT_LIMIT - 1) ? WS_DEPTH
                                                                      : icf_pkg::RESULT_LIMIT - 1;

   typedef enum logic [2:0] {
      PH_IDLE, PH_EVAL, PH_SEQ, PH_WSRD, PH_STARTER, PH_SPACE, PH_DIGITS, PH_NL
   } phase_type;

   // configuration registers
   logic        encode_ff;
   logic [63:0] seq_ff;
   logic [3:0]  seq_len_ff;
   logic [3:0]  opt_ff;
   logic [63:0] starter_ff;
   logic [3:0]  starter_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         encode_ff <= 1'b0;
         seq_ff <= 64'd59;
         seq_len_ff <= 4'd1;
         opt_ff <= '0;
         starter_ff <= '0;
         starter_len_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            icf_pkg::CSR_ENCODE_MODE: encode_ff <= csr_data[0];
            icf_pkg::CSR_COMMENT_SEQ: seq_ff <= csr_data;
            icf_pkg::CSR_COMMENT_LEN: seq_len_ff <= csr_data[3:0];
            icf_pkg::CSR_OPTION_FLAGS: opt_ff <= csr_data[3:0];
            icf_pkg::CSR_INFO_STARTER: starter_ff <= csr_data;
            icf_pkg::CSR_INFO_STARTER_LEN: starter_len_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // effective lengths
   logic [3:0] eff_len, st_len;
   always_comb begin
      eff_len = (seq_len_ff == 4'd0) ? 4'd1 : seq_len_ff;
      if (eff_len > 4'(MAX_COMMENT_LEN)) eff_len = 4'(MAX_COMMENT_LEN);
      st_len = (starter_len_ff > 4'(MAX_STARTER_LEN)) ? 4'(MAX_STARTER_LEN) : starter_len_ff;
   end

   // whitespace store memory
   logic [7:0]       ws_mem [WS_DEPTH];
   logic             ws_we;
   logic [WSA_W-1:0] ws_waddr, ws_raddr;
   logic [7:0]       ws_wdata, ws_rdata_ff;
   always_ff @(posedge clock) begin
      if (ws_we) ws_mem[ws_waddr] <= ws_wdata;
      ws_rdata_ff <= ws_mem[ws_raddr];
   end

   // datapath state
   icf_pkg::line_state_type state_ff, state_in;
   phase_type   ph_ff, ph_in;
   logic [3:0]  match_ff, match_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic        info_ff, info_in;
   logic        info_from_cws_ff, info_from_cws_in;
   logic [WSC_W-1:0] wsc_ff, wsc_in;
   logic [7:0]  byte_ff, byte_in;
   logic [3:0]  k_ff, k_in, kend_ff, kend_in;
   logic [WSC_W-1:0] wk_ff, wk_in;
   logic [DIG_W-1:0] d_ff, d_in;
   logic        started_ff, started_in;
   logic        rd_pend_ff, rd_pend_in;
   logic        ovalid_ff, ovalid_in, olast_ff, olast_in;
   logic [7:0]  obyte_ff, obyte_in;

   // BCD increment
   function automatic logic [CNT_W-1:0] bcd_inc(input logic [CNT_W-1:0] v);
      logic [CNT_W-1:0] r;
      logic carry;
      logic [4:0] d;
      r = '0;
      carry = 1'b1;
      for (int i = 0; i < LINE_DIGITS; i++) begin
         d = {1'b0, v[4*i +: 4]} + {4'd0, carry};
         carry = 1'b0;
         if (d >= 5'd10) begin
            d = d - 5'd10;
            carry = 1'b1;
         end
         r[4*i +: 4] = d[3:0];
      end
      return r;
   endfunction

   logic out_free;
   assign out_free = !ovalid_ff || rsp_ready;
   assign req_ready = (ph_ff == PH_IDLE);
   assign rsp_valid = ovalid_ff;
   assign rsp_out_byte = obyte_ff;
   assign rsp_last_of_run = olast_ff;

   logic [3:0] digit;
   assign digit = cnt_ff[4*d_ff +: 4];

   always_comb begin
      logic [7:0] c;
      logic       emit;
      logic [7:0] eb;
      logic       elast;
      c = byte_ff;
      state_in = state_ff; ph_in = ph_ff; match_in = match_ff; cnt_in = cnt_ff;
      info_in = info_ff; wsc_in = wsc_ff; byte_in = byte_ff; k_in = k_ff;
      kend_in = kend_ff; wk_in = wk_ff; d_in = d_ff; started_in = started_ff;
      info_from_cws_in = info_from_cws_ff;
      rd_pend_in = 1'b0; ovalid_in = ovalid_ff && !rsp_ready;
      olast_in = olast_ff; obyte_in = obyte_ff;
      ws_we = 1'b0; ws_waddr = wsc_ff[WSA_W-1:0]; ws_wdata = c;
      ws_raddr = wk_ff[WSA_W-1:0];
      emit = 1'b0; eb = c; elast = 1'b0;

      case (ph_ff)
         PH_IDLE: begin
            if (req_valid) begin
               byte_in = req_in_byte;
               ph_in = PH_EVAL;
            end
         end
         PH_EVAL: if (out_free) begin
            // one step of the line machine; replays hand off to a phase
            if (encode_ff) begin
               if (state_ff == icf_pkg::ST_INITIAL || state_ff == icf_pkg::ST_NEWLINE) begin
                  state_in = opt_ff[icf_pkg::OPT_FOLLOW_WS] ? icf_pkg::ST_WS : icf_pkg::ST_COPY;
                  k_in = '0; kend_in = eff_len; ph_in = PH_SEQ;
               end else if (state_ff == icf_pkg::ST_WS) begin
                  emit = 1'b1; eb = icf_pkg::CHAR_SPACE;
                  state_in = icf_pkg::ST_COPY;
               end else begin
                  emit = 1'b1; elast = 1'b1; ph_in = PH_IDLE;
                  state_in = (c == icf_pkg::CHAR_LF) ? icf_pkg::ST_NEWLINE : icf_pkg::ST_COPY;
               end
            end else begin
               case (state_ff)
                  icf_pkg::ST_INITIAL, icf_pkg::ST_NEWLINE: begin
                     if (c == seq_ff[7:0]) begin
                        match_in = 4'd1; state_in = icf_pkg::ST_PARTIAL;
                        ph_in = PH_IDLE;
                     end else if (info_ff) begin
                        info_in = 1'b0; state_in = icf_pkg::ST_COPY;
                        info_from_cws_in = 1'b0;
                        k_in = '0; ph_in = PH_STARTER;
                     end else if (c == icf_pkg::CHAR_LF) begin
                        cnt_in = bcd_inc(cnt_ff);
                        ph_in = PH_IDLE;
                        if (!opt_ff[icf_pkg::OPT_REMOVE_EMPTY]) begin
                           emit = 1'b1; elast = 1'b1;
                        end
                     end else if (icf_pkg::is_ws(c) && opt_ff[icf_pkg::OPT_REMOVE_EMPTY]) begin
                        state_in = icf_pkg::ST_WS;
                        ph_in = PH_IDLE;
                        if (!opt_ff[icf_pkg::OPT_SQUEEZE]) begin
                           ws_we = 1'b1; ws_waddr = '0; wsc_in = WSC_W'(1);
                        end else begin
                           wsc_in = '0;
                        end
                     end else begin
                        emit = 1'b1; elast = 1'b1; ph_in = PH_IDLE;
                        state_in = icf_pkg::ST_COPY;
                     end
                  end
                  icf_pkg::ST_PARTIAL: begin
                     if (match_ff >= eff_len) begin
                        state_in = opt_ff[icf_pkg::OPT_FOLLOW_WS] ? icf_pkg::ST_COMMENT_WS
                                                                   : icf_pkg::ST_COMMENT;
                     end else if (c == seq_ff[8*match_ff[2:0] +: 8]) begin
                        match_in = match_ff + 4'd1; ph_in = PH_IDLE;
                     end else begin
                        state_in = icf_pkg::ST_COPY;
                        k_in = '0; kend_in = match_ff; ph_in = PH_SEQ;
                     end
                  end
                  icf_pkg::ST_COMMENT_WS: begin
                     if (icf_pkg::is_ws(c)) begin
                        state_in = icf_pkg::ST_COMMENT;
                        if (c != icf_pkg::CHAR_LF) ph_in = PH_IDLE;
                     end else begin
                        state_in = icf_pkg::ST_COPY;
                        k_in = '0; kend_in = match_ff;
                        if (info_ff) begin
                           info_in = 1'b0; info_from_cws_in = 1'b1; ph_in = PH_STARTER;
                        end else begin
                           ph_in = PH_SEQ;
                        end
                     end
                  end
                  icf_pkg::ST_WS: begin
                     if (c == icf_pkg::CHAR_LF) begin
                        cnt_in = bcd_inc(cnt_ff);
                        state_in = icf_pkg::ST_NEWLINE; ph_in = PH_IDLE;
                     end else if (icf_pkg::is_ws(c)) begin
                        ph_in = PH_IDLE;
                        if (!opt_ff[icf_pkg::OPT_SQUEEZE] && wsc_ff < WSC_W'(WS_DEPTH)) begin
                           ws_we = 1'b1; wsc_in = wsc_ff + 1'b1;
                        end
                     end else begin
                        state_in = icf_pkg::ST_COPY;
                        if (opt_ff[icf_pkg::OPT_SQUEEZE]) begin
                           emit = 1'b1; eb = icf_pkg::CHAR_SPACE;
                        end else begin
                           wk_in = '0; ph_in = PH_WSRD;
                        end
                     end
                  end
                  icf_pkg::ST_COMMENT: begin
                     ph_in = PH_IDLE;
                     if (c == icf_pkg::CHAR_LF) begin
                        cnt_in = bcd_inc(cnt_ff);
                        if (opt_ff[icf_pkg::OPT_LINE_INFO]) info_in = 1'b1;
                        state_in = icf_pkg::ST_NEWLINE;
                     end
                  end
                  default: begin
                     emit = 1'b1; elast = 1'b1; ph_in = PH_IDLE;
                     if (c == icf_pkg::CHAR_LF) begin
                        cnt_in = bcd_inc(cnt_ff);
                        state_in = icf_pkg::ST_NEWLINE;
                     end
                  end
               endcase
            end
         end
         PH_SEQ: if (out_free) begin
            // replay comment sequence bytes
            if (k_ff >= kend_ff || k_ff >= 4'(MAX_COMMENT_LEN)) begin
               ph_in = PH_EVAL;
            end else begin
               emit = 1'b1; eb = seq_ff[8*k_ff[2:0] +: 8]; k_in = k_ff + 4'd1;
            end
         end
         PH_WSRD: begin
            // read held whitespace, one entry per beat
            if (rd_pend_ff) begin
               if (out_free) begin
                  emit = 1'b1; eb = ws_rdata_ff; wk_in = wk_ff + 1'b1;
               end else begin
                  rd_pend_in = 1'b1;
               end
            end else if (wk_ff >= wsc_ff || wk_ff >= WSC_W'(WS_REPLAY)) begin
               ph_in = PH_EVAL;
            end else begin
               rd_pend_in = 1'b1;
            end
         end
         PH_STARTER: if (out_free) begin
            if (k_ff >= st_len) begin
               emit = 1'b1; eb = icf_pkg::CHAR_SPACE;
               d_in = DIG_W'(LINE_DIGITS - 1); started_in = 1'b0; ph_in = PH_DIGITS;
            end else begin
               emit = 1'b1; eb = starter_ff[8*k_ff[2:0] +: 8]; k_in = k_ff + 4'd1;
            end
         end
         PH_DIGITS: if (out_free) begin
            // print line number, skipping leading zeros
            if (digit != 4'd0 || started_ff || d_ff == '0) begin
               emit = 1'b1; eb = icf_pkg::CHAR_ZERO + {4'd0, digit};
               started_in = 1'b1;
            end
            if (d_ff == '0) ph_in = PH_NL;
            else d_in = d_ff - 1'b1;
         end
         PH_NL: if (out_free) begin
            emit = 1'b1; eb = icf_pkg::CHAR_LF;
            // after starter from a failed whitespace check, still replay sequence
            ph_in = (kend_ff != 4'd0 && info_from_cws_ff) ? PH_SEQ : PH_EVAL;
            k_in = '0;
         end
         default: ph_in = PH_IDLE;
      endcase

      if (emit) begin
         ovalid_in = 1'b1; obyte_in = eb; olast_in = elast;
      end
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= icf_pkg::ST_INITIAL;
         ph_ff <= PH_IDLE;
         match_ff <= '0;
         cnt_ff <= CNT_W'(1);
         info_ff <= 1'b0;
         info_from_cws_ff <= 1'b0;
         wsc_ff <= '0;
         ovalid_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ph_ff <= ph_in;
         match_ff <= match_in;
         cnt_ff <= cnt_in;
         info_ff <= info_in;
         info_from_cws_ff <= info_from_cws_in;
         wsc_ff <= wsc_in;
         ovalid_ff <= ovalid_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      k_ff <= k_in;
      kend_ff <= kend_in;
      wk_ff <= wk_in;
      d_ff <= d_in;
      started_ff <= started_in;
      obyte_ff <= obyte_in;
      olast_ff <= olast_in;
   end
endmodule
`default_nettype wire

// ===== verif/inline_comment_filter_core_tb.sv =====
// Self-checking testbench for inline_comment_filter_core: a line-based stimulus
// generator, a behavioral filter predictor and a scoreboard on the result beats.
// Depends on icf_pkg and the core RTL.
`timescale 1ns / 1ps
module inline_comment_filter_core_tb;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } out_beat_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_in_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last_of_run;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [63:0] csr_data;

   inline_comment_filter_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_in_byte(req_in_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_out_byte(rsp_out_byte),
      .rsp_last_of_run(rsp_last_of_run),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // Free-running clock, 10 ns period
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   logic [7:0]   byte_q[$];
   out_beat_type filtered_q[$];
   int         send_idle_pct;
   int         recv_idle_pct;
   int         hold_tag;
   int         hold_seen;
   int         hold_cnt;
   int         mismatches;
   int         quiet_cycles;

   // Shadow configuration
   logic        cf_encode;
   logic [63:0] cf_seq;
   logic [3:0]  cf_len;
   logic [3:0]  cf_opt;
   logic [63:0] cf_starter;
   logic [3:0]  cf_starter_len;

   // Shadow filter state
   icf_pkg::line_state_type fs_state;
   int             fs_level;
   logic [39:0]    fs_line_bcd;
   logic           fs_info;
   logic [7:0]     fs_ws[32];
   int             fs_ws_cnt;

   function automatic int seq_len();
      if (cf_len == 4'd0) return 1;
      if (cf_len > 4'd8) return 8;
      return cf_len;
   endfunction

   function automatic logic ws_byte(input logic [7:0] c);
      return c == icf_pkg::CHAR_SPACE || (c >= 8'd9 && c <= 8'd13);
   endfunction

   // Work out the result beats for one input byte and append them
   function automatic void filter_byte(input logic [7:0] c);
      logic [7:0] beats[$];
      logic       done;
      logic       started;
      int         n;
      logic [3:0] d;
      logic [39:0] sum;
      logic       carry;
      done = 1'b0;
      if (cf_encode) begin
         if (fs_state == icf_pkg::ST_INITIAL || fs_state == icf_pkg::ST_NEWLINE) begin
            for (int k = 0; k < seq_len(); k++) beats.push_back(cf_seq[8*k +: 8]);
            fs_state = cf_opt[icf_pkg::OPT_FOLLOW_WS] ? icf_pkg::ST_WS : icf_pkg::ST_COPY;
         end
         if (fs_state == icf_pkg::ST_WS) beats.push_back(icf_pkg::CHAR_SPACE);
         beats.push_back(c);
         fs_state = (c == icf_pkg::CHAR_LF) ? icf_pkg::ST_NEWLINE : icf_pkg::ST_COPY;
      end else begin
         while (!done) begin
            // Line end bumps the BCD line number in copy, comment and whitespace states, and at line start
            carry = 1'b0;
            if (c == icf_pkg::CHAR_LF && (fs_state == icf_pkg::ST_COPY ||
                  fs_state == icf_pkg::ST_COMMENT || fs_state == icf_pkg::ST_WS ||
                  ((fs_state == icf_pkg::ST_INITIAL || fs_state == icf_pkg::ST_NEWLINE) &&
                   c != cf_seq[7:0] && !fs_info))) begin
               sum = fs_line_bcd;
               carry = 1'b1;
               for (int i = 0; i < 10; i++) begin
                  d = sum[4*i +: 4] + carry;
                  carry = 1'b0;
                  if (d >= 4'd10) begin
                     d = d - 4'd10;
                     carry = 1'b1;
                  end
                  sum[4*i +: 4] = d;
               end
               fs_line_bcd = sum;
            end
            case (fs_state)
               icf_pkg::ST_INITIAL, icf_pkg::ST_NEWLINE: begin
                  if (c == cf_seq[7:0]) begin
                     done = 1'b1;
                     fs_level = 1;
                     fs_state = icf_pkg::ST_PARTIAL;
                  end else if (fs_info) begin
                     n = (cf_starter_len > 4'd8) ? 8 : cf_starter_len;
                     for (int k = 0; k < n; k++) beats.push_back(cf_starter[8*k +: 8]);
                     beats.push_back(icf_pkg::CHAR_SPACE);
                     started = 1'b0;
                     for (int i = 9; i >= 0; i--) begin
                        if (fs_line_bcd[4*i +: 4] != 4'd0) started = 1'b1;
                        if (started) beats.push_back(icf_pkg::CHAR_ZERO + fs_line_bcd[4*i +: 4]);
                     end
                     if (!started) beats.push_back(icf_pkg::CHAR_ZERO);
                     beats.push_back(icf_pkg::CHAR_LF);
                     fs_info = 1'b0;
                     fs_state = icf_pkg::ST_COPY;
                  end else if (c == icf_pkg::CHAR_LF) begin
                     if (!cf_opt[icf_pkg::OPT_REMOVE_EMPTY]) beats.push_back(c);
                     done = 1'b1;
                  end else if (ws_byte(c) && cf_opt[icf_pkg::OPT_REMOVE_EMPTY]) begin
                     fs_state = icf_pkg::ST_WS;
                     fs_ws_cnt = 0;
                     if (!cf_opt[icf_pkg::OPT_SQUEEZE]) begin
                        fs_ws[0] = c;
                        fs_ws_cnt = 1;
                     end
                     done = 1'b1;
                  end else begin
                     beats.push_back(c);
                     done = 1'b1;
                     fs_state = icf_pkg::ST_COPY;
                  end
               end
               icf_pkg::ST_PARTIAL: begin
                  if (fs_level >= seq_len()) begin
                     fs_state = cf_opt[icf_pkg::OPT_FOLLOW_WS] ? icf_pkg::ST_COMMENT_WS
                                                               : icf_pkg::ST_COMMENT;
                  end else if (c == cf_seq[8*fs_level +: 8]) begin
                     done = 1'b1;
                     fs_level++;
                  end else begin
                     for (int k = 0; k < fs_level && k < 8; k++)
                        beats.push_back(cf_seq[8*k +: 8]);
                     fs_state = icf_pkg::ST_COPY;
                  end
               end
               icf_pkg::ST_COMMENT_WS: begin
                  if (ws_byte(c)) begin
                     if (c != icf_pkg::CHAR_LF) done = 1'b1;
                     fs_state = icf_pkg::ST_COMMENT;
                  end else begin
                     if (fs_info) begin
                        n = (cf_starter_len > 4'd8) ? 8 : cf_starter_len;
                        for (int k = 0; k < n; k++) beats.push_back(cf_starter[8*k +: 8]);
                        beats.push_back(icf_pkg::CHAR_SPACE);
                        started = 1'b0;
                        for (int i = 9; i >= 0; i--) begin
                           if (fs_line_bcd[4*i +: 4] != 4'd0) started = 1'b1;
                           if (started)
                              beats.push_back(icf_pkg::CHAR_ZERO + fs_line_bcd[4*i +: 4]);
                        end
                        if (!started) beats.push_back(icf_pkg::CHAR_ZERO);
                        beats.push_back(icf_pkg::CHAR_LF);
                        fs_info = 1'b0;
                     end
                     for (int k = 0; k < fs_level && k < 8; k++)
                        beats.push_back(cf_seq[8*k +: 8]);
                     fs_state = icf_pkg::ST_COPY;
                  end
               end
               icf_pkg::ST_WS: begin
                  if (c == icf_pkg::CHAR_LF) begin
                     done = 1'b1;
                     fs_state = icf_pkg::ST_NEWLINE;
                  end else if (ws_byte(c)) begin
                     if (!cf_opt[icf_pkg::OPT_SQUEEZE] && fs_ws_cnt < 32) begin
                        fs_ws[fs_ws_cnt] = c;
                        fs_ws_cnt++;
                     end
                     done = 1'b1;
                  end else begin
                     if (cf_opt[icf_pkg::OPT_SQUEEZE]) beats.push_back(icf_pkg::CHAR_SPACE);
                     else for (int k = 0; k < fs_ws_cnt; k++) beats.push_back(fs_ws[k]);
                     fs_state = icf_pkg::ST_COPY;
                  end
               end
               icf_pkg::ST_COMMENT: begin
                  done = 1'b1;
                  if (c == icf_pkg::CHAR_LF) begin
                     if (cf_opt[icf_pkg::OPT_LINE_INFO]) fs_info = 1'b1;
                     fs_state = icf_pkg::ST_NEWLINE;
                  end
               end
               default: begin
                  beats.push_back(c);
                  done = 1'b1;
                  if (c == icf_pkg::CHAR_LF) fs_state = icf_pkg::ST_NEWLINE;
               end
            endcase
         end
      end
      // Drop beats beyond the per-byte result limit and flag the last one
      while (beats.size() > icf_pkg::RESULT_LIMIT) void'(beats.pop_back());
      foreach (beats[k]) filtered_q.push_back({beats[k], k == beats.size() - 1});
   endfunction

   // Driver: advance to the next byte once the current beat is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) filter_byte(req_in_byte);
         if (!req_valid || req_ready) begin
            if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_in_byte <= byte_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_cnt <= 0;
         hold_seen <= 0;
      end else if (hold_tag != hold_seen) begin
         hold_seen <= hold_tag;
         hold_cnt <= 300;
         rsp_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= $urandom_range(99) >= recv_idle_pct;
      end
   end

   // Monitor: compare each result beat with the oldest expectation
   always @(posedge clock) begin
      out_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (filtered_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: byte %h last %b", rsp_out_byte, rsp_last_of_run);
         end else begin
            want = filtered_q.pop_front();
            if (want.out_byte !== rsp_out_byte || want.last_of_run !== rsp_last_of_run) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected byte %h last %b, got byte %h last %b",
                           want.out_byte, want.last_of_run, rsp_out_byte, rsp_last_of_run);
            end
         end
      end
   end

   // Watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > 20000) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      while (byte_q.size() > 0 || req_valid || filtered_q.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      case (idx)
         icf_pkg::CSR_ENCODE_MODE:      cf_encode = value[0];
         icf_pkg::CSR_COMMENT_SEQ:      cf_seq = value;
         icf_pkg::CSR_COMMENT_LEN:      cf_len = value[3:0];
         icf_pkg::CSR_OPTION_FLAGS:     cf_opt = value[3:0];
         icf_pkg::CSR_INFO_STARTER:     cf_starter = value;
         icf_pkg::CSR_INFO_STARTER_LEN: cf_starter_len = value[3:0];
         default: ;
      endcase
   endtask

   task automatic end_csr();
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Queue every byte of a text
   task automatic push_text(input string s);
      for (int k = 0; k < s.len(); k++) byte_q.push_back(s[k]);
   endtask

   function automatic logic [7:0] text_byte();
      return 8'(33 + $urandom_range(93));
   endfunction

   function automatic logic [7:0] space_byte();
      logic [7:0] c;
      c = ($urandom_range(3) == 0) ? 8'(9 + $urandom_range(4)) : icf_pkg::CHAR_SPACE;
      return (c == icf_pkg::CHAR_LF) ? icf_pkg::CHAR_SPACE : c;
   endfunction

   // Queue one random line shaped to exercise the filter's states
   task automatic queue_line();
      int kind;
      int n;
      kind = $urandom_range(9);
      case (kind)
         0, 1, 2: begin
            for (int k = 0; k < seq_len(); k++) byte_q.push_back(cf_seq[8*k +: 8]);
            if ($urandom_range(1)) byte_q.push_back(space_byte());
            repeat ($urandom_range(3)) byte_q.push_back(text_byte());
         end
         3: begin
            n = $urandom_range(seq_len());
            for (int k = 0; k < n; k++) byte_q.push_back(cf_seq[8*k +: 8]);
            byte_q.push_back(text_byte());
         end
         4: repeat ($urandom_range(1, 4)) byte_q.push_back(space_byte());
         5: begin
            repeat ($urandom_range(1, 4)) byte_q.push_back(space_byte());
            byte_q.push_back(text_byte());
         end
         6: ;
         7: repeat ($urandom_range(1, 3)) byte_q.push_back(8'($urandom_range(255)));
         default: repeat ($urandom_range(1, 5)) byte_q.push_back(text_byte());
      endcase
      byte_q.push_back(icf_pkg::CHAR_LF);
   endtask

   task automatic run_lines(input int count);
      repeat (count) queue_line();
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_byte = 8'h00;
      rsp_ready = 1'b0;
      csr_write = 1'b0;
      csr_index = icf_pkg::CSR_ENCODE_MODE;
      csr_data = 64'd0;
      send_idle_pct = 11;
      recv_idle_pct = 55;
      hold_tag = 0;
      mismatches = 0;
      quiet_cycles = 0;
      cf_encode = 1'b0;
      cf_seq = 64'd59;
      cf_len = 4'd1;
      cf_opt = 4'd0;
      cf_starter = 64'd0;
      cf_starter_len = 4'd0;
      fs_state = icf_pkg::ST_INITIAL;
      fs_level = 0;
      fs_line_bcd = 40'd1;
      fs_info = 1'b0;
      fs_ws_cnt = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset settings, comment line, mid-line sequence byte, edge bytes
      push_text("a;b\n;x\n\n \tq\n");
      byte_q.push_back(8'h00);
      byte_q.push_back(8'hff);
      byte_q.push_back(icf_pkg::CHAR_LF);
      wait_drained();

      // Every option, two-byte sequence, line info with a starter
      write_csr(icf_pkg::CSR_COMMENT_SEQ, 64'h2f2f);
      write_csr(icf_pkg::CSR_COMMENT_LEN, 64'd2);
      write_csr(icf_pkg::CSR_OPTION_FLAGS, 64'hf);
      write_csr(icf_pkg::CSR_INFO_STARTER, 64'h656e696c23);
      write_csr(icf_pkg::CSR_INFO_STARTER_LEN, 64'd5);
      end_csr();
      // Comment then a word, follow-whitespace failure, empty line with spaces
      push_text("// x\n// y\nab\n//z\n  \n  k\n");
      wait_drained();

      // Long hold-off on the receiver while bytes keep coming
      hold_tag = hold_tag + 1;
      run_lines(5);

      // Remove empty lines without squeezing; overflow the whitespace store
      write_csr(icf_pkg::CSR_OPTION_FLAGS, 64'h1);
      end_csr();
      repeat (40) byte_q.push_back(icf_pkg::CHAR_SPACE);
      byte_q.push_back("w");
      byte_q.push_back(icf_pkg::CHAR_LF);
      run_lines(6);

      // Sender switches to heavy idling, receiver to light
      send_idle_pct = 55;
      recv_idle_pct = 11;
      write_csr(icf_pkg::CSR_COMMENT_SEQ, 64'hffffffffffffffff);
      write_csr(icf_pkg::CSR_COMMENT_LEN, 64'd15);
      write_csr(icf_pkg::CSR_OPTION_FLAGS, 64'h6);
      end_csr();
      run_lines(6);
      write_csr(icf_pkg::CSR_COMMENT_SEQ, 64'h00);
      write_csr(icf_pkg::CSR_COMMENT_LEN, 64'd0);
      write_csr(icf_pkg::CSR_OPTION_FLAGS, 64'hb);
      write_csr(icf_pkg::CSR_INFO_STARTER, 64'hffffffffffffffff);
      write_csr(icf_pkg::CSR_INFO_STARTER_LEN, 64'd15);
      end_csr();
      run_lines(6);

      // Encode mode with and without the trailing space
      write_csr(icf_pkg::CSR_ENCODE_MODE, 64'd1);
      write_csr(icf_pkg::CSR_COMMENT_SEQ, 64'h2023);
      write_csr(icf_pkg::CSR_COMMENT_LEN, 64'd8);
      write_csr(icf_pkg::CSR_OPTION_FLAGS, 64'h4);
      end_csr();
      run_lines(4);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(icf_pkg::CSR_OPTION_FLAGS, 64'h0);
      write_csr(icf_pkg::CSR_COMMENT_LEN, 64'd1);
      end_csr();
      run_lines(4);

      // Back to decode, random eight-byte sequence, all options
      write_csr(icf_pkg::CSR_ENCODE_MODE, 64'd0);
      write_csr(icf_pkg::CSR_COMMENT_SEQ, {$urandom, $urandom});
      write_csr(icf_pkg::CSR_COMMENT_LEN, 64'd8);
      write_csr(icf_pkg::CSR_OPTION_FLAGS, 64'hf);
      write_csr(icf_pkg::CSR_INFO_STARTER_LEN, 64'd0);
      end_csr();
      run_lines(6);
      write_csr(icf_pkg::CSR_COMMENT_SEQ, 64'h3b);
      write_csr(icf_pkg::CSR_COMMENT_LEN, 64'd1);
      end_csr();
      run_lines(4);

      if (mismatches == 0 && filtered_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
